>>> src/audio_pes_ts_packetizer_assert.svh
// Assertion macros for the packetizer; compiled out when ASSERT_OFF is set.
`ifndef AUDIO_PES_TS_PACKETIZER_ASSERT_SVH
`define AUDIO_PES_TS_PACKETIZER_ASSERT_SVH
`ifndef ASSERT_OFF
`define APTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define APTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define APTS_ASSERT_NOW(lbl, ante, cons)
`define APTS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> src/apts_pkg.sv
package apts_pkg;

  localparam int unsigned TS_SIZE = 188;

  localparam logic [2:0] CFG_CODEC_MODE  = 3'd0;
  localparam logic [2:0] CFG_PID         = 3'd1;
  localparam logic [2:0] CFG_AAC_PROFILE = 3'd2;
  localparam logic [2:0] CFG_SAMPLE_RATE = 3'd3;
  localparam logic [2:0] CFG_CHANNEL     = 3'd4;

  localparam logic MODE_AAC = 1'b0;

  typedef struct packed {
    logic latch_in;
    logic frame_init;
    logic set_err;
    logic pkt_start;
    logic hdr_emit;
    logic data_emit;
  } apts_cmd_t;

  typedef struct packed {
    logic frame_start;
    logic aac_mode;
    logic len_bad;
    logic len_zero;
    logic dropping;
    logic rem_zero;
    logic pos_zero;
    logic hdr_last;
    logic place_last;
    logic can_emit;
  } apts_status_t;

endpackage

>>> src/apts_ctrl.sv
module apts_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  apts_pkg::apts_status_t st,
  output apts_pkg::apts_cmd_t    cmd
);
  import apts_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_ERR    = 6'b000100,
    S_PLACE  = 6'b001000,
    S_HDR    = 6'b010000,
    S_DATA   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (st.frame_start) begin
          cmd.frame_init = 1'b1;
          if (st.aac_mode && st.len_bad) state_next = S_ERR;
          else if (!st.aac_mode && st.len_zero) state_next = S_IDLE;
          else state_next = S_PLACE;
        end else if (st.dropping || st.rem_zero) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_ERR: begin
        if (st.can_emit) begin
          cmd.set_err = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_PLACE: begin
        // open a new transport packet when the previous one is complete
        if (st.pos_zero) begin
          cmd.pkt_start = 1'b1;
          state_next    = S_HDR;
        end else begin
          state_next = S_DATA;
        end
      end
      S_HDR: begin
        if (st.can_emit) begin
          cmd.hdr_emit = 1'b1;
          if (st.hdr_last) state_next = S_DATA;
        end
      end
      S_DATA: begin
        if (st.can_emit) begin
          cmd.data_emit = 1'b1;
          state_next    = st.place_last ? S_IDLE : S_PLACE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> src/apts_dp.sv
module apts_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [2:0]            cfg_index,
  input  logic [12:0]           cfg_data,
  input  logic [7:0]            payload_byte,
  input  logic                  frame_start,
  input  logic [15:0]           frame_len,
  input  logic [32:0]           pts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [63:0]           packet_word,
  output logic [3:0]            byte_count,
  output logic                  packet_end,
  output logic                  frame_error,
  input  apts_pkg::apts_cmd_t    cmd,
  output apts_pkg::apts_status_t st
);
  import apts_pkg::*;

  // configuration
  logic        codec_mode;
  logic [12:0] pid;
  logic [1:0]  aac_profile;
  logic [3:0]  sample_rate_index;
  logic [2:0]  channel_config;

  // latched request
  logic [7:0]  byte_q;
  logic        fs_q;
  logic [15:0] len_q;
  logic [32:0] frame_pts;

  // packetizer state
  logic [3:0]  continuity_counter;
  logic [15:0] bytes_remaining;
  logic        first_pending;
  logic [7:0]  packet_position;
  logic [63:0] word_buffer;
  logic [3:0]  word_fill;
  logic        dropping;
  logic        adts_q;
  logic [2:0]  place_idx;

  // per-packet header fields
  logic [7:0]  hdr_idx;
  logic [7:0]  stuff;
  logic        first_q;
  logic [12:0] pid_q;
  logic [15:0] plen;

  logic [15:0] fl;
  logic [7:0]  adts_byte, place_byte, hdr_byte, emit_byte;
  logic [7:0]  room, stuff_new, pes_idx, stuff_idx, hdr_end;
  logic [15:0] pv1, pv2;
  logic [16:0] plen_wide;
  logic [63:0] word_ins;
  logic [3:0]  fill_inc;
  logic [7:0]  pos_inc;
  logic        emit_en;

  assign fl = len_q + 16'd7;

  always_comb begin
    case (place_idx)
      3'd0: adts_byte = 8'hFF;
      3'd1: adts_byte = 8'hF9;
      3'd2: adts_byte = {aac_profile, sample_rate_index, 1'b0, channel_config[2]};
      3'd3: adts_byte = {channel_config[1:0], 4'b0000, fl[12:11]};
      3'd4: adts_byte = fl[10:3];
      3'd5: adts_byte = {fl[2:0], 5'h1F};
      3'd6: adts_byte = 8'hFC;
      default: adts_byte = byte_q;
    endcase
    place_byte = adts_q ? adts_byte : byte_q;
  end

  always_comb begin
    room      = first_pending ? 8'd170 : 8'd184;
    stuff_new = (bytes_remaining >= {8'd0, room}) ? 8'd0 : room - bytes_remaining[7:0];
    plen_wide = {1'b0, bytes_remaining} + 17'd8;
  end

  always_comb begin
    stuff_idx = hdr_idx - 8'd4;
    pes_idx   = hdr_idx - 8'd4 - stuff;
    pv1       = {frame_pts[29:15], 1'b1};
    pv2       = {frame_pts[14:0], 1'b1};
    hdr_end   = stuff + 8'd3 + (first_q ? 8'd14 : 8'd0);
    if (hdr_idx < 8'd4) begin
      case (hdr_idx[1:0])
        2'd0: hdr_byte = 8'h47;
        2'd1: hdr_byte = {1'b0, first_q, 1'b0, pid_q[12:8]};
        2'd2: hdr_byte = pid_q[7:0];
        default: hdr_byte = {2'b00, (stuff != 8'd0), 1'b1, continuity_counter};
      endcase
    end else if (stuff_idx < stuff) begin
      if (stuff_idx == 8'd0) hdr_byte = stuff - 8'd1;
      else if (stuff_idx == 8'd1) hdr_byte = 8'h00;
      else hdr_byte = 8'hFF;
    end else begin
      case (pes_idx)
        8'd0:  hdr_byte = 8'h00;
        8'd1:  hdr_byte = 8'h00;
        8'd2:  hdr_byte = 8'h01;
        8'd3:  hdr_byte = 8'hC0;
        8'd4:  hdr_byte = plen[15:8];
        8'd5:  hdr_byte = plen[7:0];
        8'd6:  hdr_byte = 8'h80;
        8'd7:  hdr_byte = 8'h80;
        8'd8:  hdr_byte = 8'h05;
        8'd9:  hdr_byte = {4'h2, frame_pts[32:30], 1'b1};
        8'd10: hdr_byte = pv1[15:8];
        8'd11: hdr_byte = pv1[7:0];
        8'd12: hdr_byte = pv2[15:8];
        default: hdr_byte = pv2[7:0];
      endcase
    end
  end

  always_comb begin
    emit_en   = cmd.hdr_emit | cmd.data_emit;
    emit_byte = cmd.hdr_emit ? hdr_byte : place_byte;
    word_ins  = word_buffer;
    word_ins[{3'd7 - word_fill[2:0], 3'b000} +: 8] = emit_byte;
    fill_inc  = word_fill + 4'd1;
    pos_inc   = packet_position + 8'd1;
  end

  always_comb begin
    st.frame_start = fs_q;
    st.aac_mode    = (codec_mode == MODE_AAC);
    st.len_bad     = (len_q == 16'd0) || (len_q > 16'h1FFF);
    st.len_zero    = (len_q == 16'd0);
    st.dropping    = dropping;
    st.rem_zero    = (bytes_remaining == 16'd0);
    st.pos_zero    = (packet_position == 8'd0);
    st.hdr_last    = (hdr_idx == hdr_end);
    st.place_last  = adts_q ? (place_idx == 3'd7) : 1'b1;
    st.can_emit    = !out_valid || out_ready;
  end

  // payload and per-packet header registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      byte_q <= payload_byte;
      len_q  <= frame_len;
      if (frame_start) frame_pts <= pts;
    end
    if (cmd.pkt_start) begin
      stuff <= stuff_new;
      pid_q <= pid;
      plen  <= plen_wide[16] ? 16'd0 : plen_wide[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      codec_mode         <= 1'b0;
      pid                <= 13'd256;
      aac_profile        <= 2'd1;
      sample_rate_index  <= 4'd4;
      channel_config     <= 3'd2;
      fs_q               <= 1'b0;
      continuity_counter <= '0;
      bytes_remaining    <= '0;
      first_pending      <= 1'b0;
      packet_position    <= '0;
      word_buffer        <= '0;
      word_fill          <= '0;
      dropping           <= 1'b0;
      adts_q             <= 1'b0;
      place_idx          <= '0;
      hdr_idx            <= '0;
      first_q            <= 1'b0;
      out_valid          <= 1'b0;
      packet_word        <= '0;
      byte_count         <= '0;
      packet_end         <= 1'b0;
      frame_error        <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_CODEC_MODE:  codec_mode        <= cfg_data[0];
          CFG_PID:         pid               <= cfg_data;
          CFG_AAC_PROFILE: aac_profile       <= cfg_data[1:0];
          CFG_SAMPLE_RATE: sample_rate_index <= cfg_data[3:0];
          CFG_CHANNEL:     channel_config    <= cfg_data[2:0];
          default: ;
        endcase
      end

      if (out_ready) out_valid <= 1'b0;

      if (cmd.latch_in) begin
        fs_q      <= frame_start;
        adts_q    <= 1'b0;
        place_idx <= '0;
      end

      if (cmd.frame_init) begin
        packet_position <= '0;
        word_buffer     <= '0;
        word_fill       <= '0;
        bytes_remaining <= '0;
        first_pending   <= 1'b0;
        dropping        <= 1'b0;
        if (codec_mode == MODE_AAC) begin
          if (st.len_bad) begin
            dropping <= 1'b1;
          end else begin
            bytes_remaining <= fl;
            first_pending   <= 1'b1;
            adts_q          <= 1'b1;
          end
        end else if (len_q != 16'd0) begin
          bytes_remaining <= len_q;
          first_pending   <= 1'b1;
        end
      end

      if (cmd.set_err) begin
        out_valid   <= 1'b1;
        packet_word <= '0;
        byte_count  <= '0;
        packet_end  <= 1'b0;
        frame_error <= 1'b1;
      end

      if (cmd.pkt_start) begin
        continuity_counter <= continuity_counter + 4'd1;
        first_q            <= first_pending;
        first_pending      <= 1'b0;
        hdr_idx            <= '0;
      end

      if (cmd.hdr_emit) hdr_idx <= hdr_idx + 8'd1;

      if (cmd.data_emit) begin
        bytes_remaining <= bytes_remaining - 16'd1;
        place_idx       <= place_idx + 3'd1;
      end

      if (emit_en) begin
        if (pos_inc == 8'(TS_SIZE) || fill_inc == 4'd8) begin
          out_valid   <= 1'b1;
          packet_word <= word_ins;
          byte_count  <= fill_inc;
          packet_end  <= (pos_inc == 8'(TS_SIZE));
          frame_error <= 1'b0;
          word_buffer <= '0;
          word_fill   <= '0;
        end else begin
          word_buffer <= word_ins;
          word_fill   <= fill_inc;
        end
        packet_position <= (pos_inc == 8'(TS_SIZE)) ? 8'd0 : pos_inc;
      end
    end
  end

endmodule

>>> src/audio_pes_ts_packetizer.sv
// Audio PES / MPEG-2 transport stream packetizer. One request is one payload
// byte; the first byte of a frame (frame_start) also carries frame_len and
// a 33-bit PTS. Each frame is wrapped in a PES packet (stream 0xC0, PTS only)
// and cut into 188-byte transport packets that leave as words of up to eight
// bytes, first byte in bits 63..56; packet_end marks the last word of a
// packet. In AAC mode (codec_mode 0) a 7-byte ADTS header is placed ahead of
// the payload, and a length of 0 or above 8191 gives one word with
// frame_error set, after which the frame's bytes are dropped. Configuration
// writes are taken any time but must only be issued while the block is idle.
// Timing: one request at a time. A request passes an accept state and a decode
// state, then two steps per placed byte (one to step the controller, one in the
// byte-wide emit path); an ignored byte ends after the decode. A byte that opens
// a packet first walks its header, 4 to 187 bytes, at one header byte per cycle
// while the output can take a byte. Output back-pressure stalls the emit path
// while the output register is full.
module audio_pes_ts_packetizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  payload_byte,
  input  logic        frame_start,
  input  logic [15:0] frame_len,
  input  logic [32:0] pts,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] packet_word,
  output logic [3:0]  byte_count,
  output logic        packet_end,
  output logic        frame_error
);
  import apts_pkg::*;

  apts_cmd_t    cmd;
  apts_status_t st;

  // sequencer: decode request, walk packet header, place bytes
  apts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // byte generation, word assembly and output register
  apts_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .payload_byte (payload_byte),
    .frame_start  (frame_start),
    .frame_len    (frame_len),
    .pts          (pts),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .packet_word  (packet_word),
    .byte_count   (byte_count),
    .packet_end   (packet_end),
    .frame_error  (frame_error),
    .cmd          (cmd),
    .st           (st)
  );

`include "audio_pes_ts_packetizer_assert.svh"

  // one request in flight: ready drops right after an accept
  `APTS_ASSERT_NEXT(a_one_request, in_valid && in_ready, !in_ready)
  // an error word carries no bytes
  `APTS_ASSERT_NOW(a_err_empty, out_valid && frame_error, byte_count == 4'd0 && !packet_end)
  // words inside a packet are always full
  `APTS_ASSERT_NOW(a_full_word, out_valid && !packet_end && !frame_error, byte_count == 4'd8)

endmodule

>>> sim/tb_audio_pes_ts_packetizer.sv
module tb_audio_pes_ts_packetizer;
  timeunit 1ns;
  timeprecision 1ps;
  import apts_pkg::*;

  localparam int IDLE_LIMIT = 4000;   // cycles with no handshake on either side
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 250;  // covers the longest packet-start header burst

  // Expected word stream of the packetizer: a model of the framing state plus
  // the queue of words it still owes.
  class ts_word_scoreboard;
    typedef struct {
      logic [63:0] word;
      logic [3:0]  cnt;
      logic        pend;
      logic        err;
    } ts_word_t;

    ts_word_t    owed[$];
    int          errors;
    int          words_seen;
    int          packets_seen;
    // configuration
    logic        codec;
    logic [12:0] pid_r;
    logic [1:0]  profile_r;
    logic [3:0]  sri_r;
    logic [2:0]  chan_r;
    // framing state
    logic [3:0]  cc;
    int unsigned remaining;
    bit          first_pending;
    int unsigned pos;
    logic [63:0] acc_word;
    int unsigned fill;
    bit          dropping;
    logic [32:0] frame_pts;

    function new();
      codec = MODE_AAC; pid_r = 13'd256; profile_r = 2'd1; sri_r = 4'd4; chan_r = 3'd2;
      cc = '0; remaining = 0; first_pending = 0; pos = 0; acc_word = '0; fill = 0;
      dropping = 0; frame_pts = '0; errors = 0; words_seen = 0; packets_seen = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [12:0] data);
      case (idx)
        CFG_CODEC_MODE:  codec = data[0];
        CFG_PID:         pid_r = data;
        CFG_AAC_PROFILE: profile_r = data[1:0];
        CFG_SAMPLE_RATE: sri_r = data[3:0];
        CFG_CHANNEL:     chan_r = data[2:0];
        default: ;
      endcase
    endfunction

    function void owe(logic [63:0] w, logic [3:0] c, logic e, logic er);
      ts_word_t t;
      t.word = w; t.cnt = c; t.pend = e; t.err = er;
      owed.push_back(t);
    endfunction

    // Pack one byte into the output word; flush on a full word or packet end.
    function void put_byte(logic [7:0] b);
      acc_word |= 64'(b) << (56 - 8 * fill);
      fill++;
      pos++;
      if (pos >= TS_SIZE) begin
        owe(acc_word, 4'(fill), 1'b1, 1'b0);
        acc_word = '0; fill = 0; pos = 0;
      end else if (fill >= 8) begin
        owe(acc_word, 4'(fill), 1'b0, 1'b0);
        acc_word = '0; fill = 0;
      end
    endfunction

    function void open_packet();
      int unsigned hdr, len, stuff, plen;
      logic [15:0] v;
      hdr = first_pending ? 18 : 4;
      len = TS_SIZE - hdr;
      if (len > remaining) len = remaining;
      stuff = TS_SIZE - hdr - len;
      cc = cc + 4'd1;
      put_byte(8'h47);
      put_byte({first_pending ? 3'b010 : 3'b000, pid_r[12:8]});
      put_byte(pid_r[7:0]);
      put_byte({(stuff > 0) ? 4'h3 : 4'h1, cc});
      if (stuff > 0) begin
        put_byte(8'(stuff - 1));
        if (stuff >= 2) begin
          put_byte(8'h00);
          for (int i = 2; i < stuff; i++) put_byte(8'hFF);
        end
      end
      if (first_pending) begin
        plen = remaining + 8;
        if (plen > 32'hFFFF) plen = 0;
        put_byte(8'h00); put_byte(8'h00); put_byte(8'h01); put_byte(8'hC0);
        put_byte(8'(plen >> 8)); put_byte(8'(plen));
        put_byte(8'h80); put_byte(8'h80); put_byte(8'd5);
        put_byte({4'h2, frame_pts[32:30], 1'b1});
        v = {frame_pts[29:15], 1'b1};
        put_byte(v[15:8]); put_byte(v[7:0]);
        v = {frame_pts[14:0], 1'b1};
        put_byte(v[15:8]); put_byte(v[7:0]);
        first_pending = 0;
      end
    endfunction

    function void place(logic [7:0] b);
      if (remaining == 0) return;
      if (pos == 0) open_packet();
      put_byte(b);
      remaining--;
    endfunction

    // Accepted request: advance the framing state and queue the words it causes.
    function void note_request(logic [7:0] b, logic fs, logic [15:0] flen, logic [32:0] p);
      int unsigned fl;
      if (fs) begin
        frame_pts = p;
        pos = 0; acc_word = '0; fill = 0; remaining = 0; first_pending = 0; dropping = 0;
        if (codec == MODE_AAC) begin
          if (flen == 0 || flen > 16'h1FFF) begin
            dropping = 1;
            owe(64'd0, 4'd0, 1'b0, 1'b1);
            return;
          end
          fl = flen + 7;
          remaining = fl;
          first_pending = 1;
          place(8'hFF);
          place(8'hF9);
          place({profile_r, sri_r, 1'b0, chan_r[2]});
          place({chan_r[1:0], 4'b0000, 2'(fl >> 11)});
          place(8'(fl >> 3));
          place({3'(fl), 5'h1F});
          place(8'hFC);
          place(b);
        end else begin
          if (flen == 0) return;
          remaining = flen;
          first_pending = 1;
          place(b);
        end
        return;
      end
      if (dropping || remaining == 0) return;
      place(b);
    endfunction

    function void check_result(logic [63:0] w, logic [3:0] c, logic e, logic er);
      ts_word_t t;
      words_seen++;
      if (e) packets_seen++;
      if (owed.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual word=%h count=%0d end=%b err=%b",
                 $time, w, c, e, er);
        errors++;
        return;
      end
      t = owed[0];
      owed.delete(0);
      if (w !== t.word) begin
        $display("%0t: packet_word expected %h actual %h", $time, t.word, w);
        errors++;
      end
      if (c !== t.cnt) begin
        $display("%0t: byte_count expected %0d actual %0d", $time, t.cnt, c);
        errors++;
      end
      if (e !== t.pend) begin
        $display("%0t: packet_end expected %b actual %b", $time, t.pend, e);
        errors++;
      end
      if (er !== t.err) begin
        $display("%0t: frame_error expected %b actual %b", $time, t.err, er);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  payload_byte;
  logic        frame_start;
  logic [15:0] frame_len;
  logic [32:0] pts;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] packet_word;
  logic [3:0]  byte_count;
  logic        packet_end;
  logic        frame_error;

  ts_word_scoreboard sb;
  bit idle_on;      // random gaps on both sides
  bit hold_req;     // ask the receiver for one long hold-off
  int sent;         // requests counted toward the run length
  int quiet_cnt;

  audio_pes_ts_packetizer DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .payload_byte(payload_byte), .frame_start(frame_start),
    .frame_len(frame_len), .pts(pts),
    .out_valid(out_valid), .out_ready(out_ready),
    .packet_word(packet_word), .byte_count(byte_count),
    .packet_end(packet_end), .frame_error(frame_error)
  );

  always #5 clk = ~clk;

  // Check every accepted word against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(packet_word, byte_count, packet_end, frame_error);
  end

  // Watchdog: end the run when no handshake happens for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) begin
      quiet_cnt <= 0;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
      if (quiet_cnt >= IDLE_LIMIT) begin
        $display("%0t: timeout, %0d words still expected", $time, sb.owed.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Receiver: random ready bursts, one long hold-off on request, none in the tail.
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
        out_ready <= 1'b1;
      end else if (!idle_on || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 17) - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(posedge clk);
      end
    end
  end

  // Offer one request and hold it until accepted; leave valid high afterwards.
  task automatic send_req(logic [7:0] b, logic fs, logic [15:0] flen, logic [32:0] p);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    payload_byte <= b;
    frame_start  <= fs;
    frame_len    <= flen;
    pts          <= p;
    do @(posedge clk); while (!in_ready);
    sb.note_request(b, fs, flen, p);
  endtask

  function automatic logic [32:0] rand_pts();
    return {1'($urandom_range(0, 1)), 32'($urandom)};
  endfunction

  // Send the first nbytes of a frame; fewer than flen means it gets cut short.
  task automatic send_frame(logic [15:0] flen, int nbytes);
    for (int i = 0; i < nbytes; i++) begin
      send_req(8'($urandom), i == 0, (i == 0) ? flen : 16'($urandom), rand_pts());
      sent++;
    end
  endtask

  task automatic stray_byte();
    send_req(8'($urandom), 1'b0, 16'($urandom), rand_pts());
  endtask

  // Drop valid and wait for every owed word, then let a packet-start burst finish.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [12:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic write_all(logic mode, logic [12:0] p, logic [1:0] prof,
                           logic [3:0] sri, logic [2:0] ch);
    write_reg(CFG_CODEC_MODE, 13'(mode));
    write_reg(CFG_PID, p);
    write_reg(CFG_AAC_PROFILE, 13'(prof));
    write_reg(CFG_SAMPLE_RATE, 13'(sri));
    write_reg(CFG_CHANNEL, 13'(ch));
  endtask

  // One random frame or piece of noise, shaped mostly as well-formed frames.
  task automatic random_frame();
    int r, len;
    int edges[9] = '{1, 169, 170, 171, 182, 183, 184, 185, 186};
    logic [15:0] flen;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      // noise between frames: ignored bytes
      repeat ($urandom_range(1, 3)) stray_byte();
    end else if (r < 20) begin
      // broken frame: any length, cut short (AAC errors land here)
      flen = 16'($urandom);
      send_frame(flen, $urandom_range(1, 12));
    end else if (r < 28) begin
      // lengths around a full first packet and around one-byte stuffing
      len = edges[$urandom_range(0, 8)];
      if (sb.codec == MODE_AAC && len > 7) len = len - 7;
      send_frame(16'(len), len);
    end else begin
      len = $urandom_range(1, 40);
      send_frame(16'(len), ($urandom_range(0, 4) == 0) ? $urandom_range(1, len) : len);
    end
  endtask

  initial begin
    int phase_goal;
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0; cfg_index = CFG_CODEC_MODE; cfg_data = '0;
    in_valid = 1'b0; payload_byte = '0; frame_start = 1'b0;
    frame_len = '0; pts = '0;
    out_ready = 1'b0;
    idle_on = 1; hold_req = 0; sent = 0; quiet_cnt = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, AAC at reset settings: bad lengths, drop, max length, tiny frame.
    send_frame(16'd0, 1);
    stray_byte();
    send_frame(16'd8192, 2);
    send_frame(16'hFFFF, 1);
    send_frame(16'd8191, 3);
    send_frame(16'd1, 1);
    stray_byte();
    stray_byte();
    drain();

    // Directed, MP3: empty frame, PES length overflow and limit, tiny frames.
    write_all(1'b1, 13'd0, 2'd1, 4'd4, 3'd2);
    send_frame(16'd0, 1);
    send_frame(16'hFFFF, 2);
    send_frame(16'd65527, 2);
    send_frame(16'd1, 1);
    send_frame(16'd2, 2);
    send_frame(16'd3, 1);
    drain();

    // Random phases, each with its own settings, extremes first.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_all(MODE_AAC, 13'h1FFF, 2'd3, 4'd15, 3'd7);
        1: write_all(1'b1, 13'($urandom), 2'($urandom), 4'($urandom), 3'($urandom));
        2: write_all(MODE_AAC, 13'd0, 2'd0, 4'd0, 3'd0);
        default: write_all(1'($urandom), 13'($urandom), 2'($urandom),
                           4'($urandom), 3'($urandom));
      endcase
      if (ph == 5) idle_on = 0;  // no idling in the tail
      phase_goal = sent + 30;
      while (sent < phase_goal) begin
        if (ph == 1 && sent > phase_goal - 40) begin
          // hold the receiver off while requests keep coming
          if (!hold_req) hold_req = 1;
          send_frame(16'd80, 80);
          while (hold_req) send_frame(16'd20, 20);
        end else begin
          random_frame();
        end
      end
      // pause the sender until everything owed has arrived
      drain();
    end

    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d frame bytes over 8 register settings (AAC and MP3, extreme pids).",
             sent);
    $display("Checked %0d output words, %0d complete transport packets.",
             sb.words_seen, sb.packets_seen);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
